### rtl/trb_pkg.sv
// Shared types and constants for the TCP reset builder.
// No dependencies; every rtl file imports this package.
package trb_pkg;

    // Bit positions in the observed TCP flag byte
    localparam int unsigned FlagFin = 0;
    localparam int unsigned FlagSyn = 1;
    localparam int unsigned FlagAck = 4;

    localparam logic [7:0]  ProtoTcp    = 8'd6;
    localparam logic [15:0] TcpHdrBytes = 16'd20;
    // Data offset 5, flags RST|ACK
    localparam logic [15:0] RstOffFlags = 16'h5014;

    // Pseudo-header zero/proto word plus TCP length plus offset/flags word
    localparam logic [15:0] SumConst = {8'd0, ProtoTcp} + TcpHdrBytes + RstOffFlags;

    // Eleven 16-bit terms at most; the running sum fits in 20 bits
    localparam int unsigned SumW = 20;

    // Stage 1: decoded request
    typedef struct packed {
        logic            valid;
        logic [31:0]     rst_src_ip;
        logic [31:0]     rst_dst_ip;
        logic [15:0]     rst_src_port;
        logic [15:0]     rst_dst_port;
        logic [31:0]     seq;
        logic [31:0]     payload;
        logic [1:0]      inc;
        logic [31:0]     rst_seq;
        logic [SumW-1:0] sum;
    } t_s1;

    // Stages 2 and 3: reset ack known, checksum accumulating
    typedef struct packed {
        logic            valid;
        logic [31:0]     rst_src_ip;
        logic [31:0]     rst_dst_ip;
        logic [15:0]     rst_src_port;
        logic [15:0]     rst_dst_port;
        logic [31:0]     rst_seq;
        logic [31:0]     rst_ack;
        logic [SumW-1:0] sum;
    } t_s2;

endpackage

### rtl/trb_prep.sv
// First pipeline stage: swap addresses, pick reset seq, payload length, header sums.
// Depends on trb_pkg.
module trb_prep (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req,
    input  logic [31:0]   i_src_ip,
    input  logic [31:0]   i_dst_ip,
    input  logic [15:0]   i_src_port,
    input  logic [15:0]   i_dst_port,
    input  logic [31:0]   i_seq_number,
    input  logic [31:0]   i_ack_number,
    input  logic [7:0]    i_tcp_flags,
    input  logic [15:0]   i_total_length,
    input  logic [3:0]    i_ip_header_words,
    input  logic [3:0]    i_tcp_header_words,
    output trb_pkg::t_s1  o_s1
);
    import trb_pkg::*;

    t_s1 r_s1;
    t_s1 n_s1;

    always_comb begin
        n_s1.valid        = i_req;
        n_s1.rst_src_ip   = i_dst_ip;
        n_s1.rst_dst_ip   = i_src_ip;
        n_s1.rst_src_port = i_dst_port;
        n_s1.rst_dst_port = i_src_port;
        n_s1.seq          = i_seq_number;
        // Payload wraps modulo 2^32 when headers exceed the packet
        n_s1.payload      = {16'd0, i_total_length}
                          - {26'd0, i_ip_header_words, 2'b00}
                          - {26'd0, i_tcp_header_words, 2'b00};
        n_s1.inc          = {1'b0, i_tcp_flags[FlagSyn]} + {1'b0, i_tcp_flags[FlagFin]};
        n_s1.rst_seq      = i_tcp_flags[FlagAck] ? i_ack_number : 32'd0;
        n_s1.sum          = SumW'(i_dst_ip[31:16]) + SumW'(i_dst_ip[15:0])
                          + SumW'(i_src_ip[31:16]) + SumW'(i_src_ip[15:0])
                          + SumW'(i_dst_port) + SumW'(i_src_port)
                          + SumW'(SumConst);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

### rtl/trb_acc.sv
// Second and third pipeline stages: form reset ack, add seq and ack words to the sum.
// Depends on trb_pkg.
module trb_acc (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  trb_pkg::t_s1  i_s1,
    output trb_pkg::t_s2  o_s3
);
    import trb_pkg::*;

    t_s2 r_s2;
    t_s2 n_s2;
    t_s2 r_s3;
    t_s2 n_s3;

    always_comb begin
        n_s2.valid        = i_s1.valid;
        n_s2.rst_src_ip   = i_s1.rst_src_ip;
        n_s2.rst_dst_ip   = i_s1.rst_dst_ip;
        n_s2.rst_src_port = i_s1.rst_src_port;
        n_s2.rst_dst_port = i_s1.rst_dst_port;
        n_s2.rst_seq      = i_s1.rst_seq;
        n_s2.rst_ack      = i_s1.seq + i_s1.payload + {30'd0, i_s1.inc};
        n_s2.sum          = i_s1.sum + SumW'(i_s1.rst_seq[31:16])
                          + SumW'(i_s1.rst_seq[15:0]);
    end

    always_comb begin
        n_s3     = r_s2;
        n_s3.sum = r_s2.sum + SumW'(r_s2.rst_ack[31:16]) + SumW'(r_s2.rst_ack[15:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
            r_s3 <= '0;
        end else begin
            r_s2 <= n_s2;
            r_s3 <= n_s3;
        end
    end

    assign o_s3 = r_s3;

endmodule

### rtl/trb_fold.sv
// Last pipeline stage: fold the carries, complement, register the result ports.
// Depends on trb_pkg.
module trb_fold (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  trb_pkg::t_s2  i_s3,
    output logic          o_valid,
    output logic [31:0]   o_rst_src_ip,
    output logic [31:0]   o_rst_dst_ip,
    output logic [15:0]   o_rst_src_port,
    output logic [15:0]   o_rst_dst_port,
    output logic [31:0]   o_rst_seq,
    output logic [31:0]   o_rst_ack,
    output logic [15:0]   o_tcp_checksum
);
    import trb_pkg::*;

    logic [16:0] fold1;
    logic [16:0] fold2;
    logic [15:0] n_csum;
    logic        r_valid;
    t_s2         r_out;
    logic [15:0] r_csum;

    always_comb begin
        fold1  = {13'd0, i_s3.sum[SumW-1:16]} + {1'b0, i_s3.sum[15:0]};
        fold2  = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
        n_csum = ~fold2[15:0];
    end

    always_ff @(posedge i_clk) begin
        r_out  <= i_s3;
        r_csum <= n_csum;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_s3.valid;
        end
    end

    assign o_valid        = r_valid;
    assign o_rst_src_ip   = r_out.rst_src_ip;
    assign o_rst_dst_ip   = r_out.rst_dst_ip;
    assign o_rst_src_port = r_out.rst_src_port;
    assign o_rst_dst_port = r_out.rst_dst_port;
    assign o_rst_seq      = r_out.rst_seq;
    assign o_rst_ack      = r_out.rst_ack;
    assign o_tcp_checksum = r_csum;

endmodule

### rtl/tcp_reset_builder.sv
// Top level of the TCP reset builder: four-stage pipeline.
// Depends on trb_pkg, trb_prep, trb_acc and trb_fold.
//
// Usage:
//   Drive the header fields of one observed IPv4/TCP segment on the i_* ports
//   and raise start. A request is taken at each rising edge with start high
//   and busy low. The answering reset segment fields (swapped addresses and
//   ports, reset seq/ack and the TCP checksum over pseudo-header and a fixed
//   20-byte RST|ACK header) appear on the o_* ports with o_valid high for
//   exactly one cycle.
// Throughput: one request per cycle, sustained while busy is low; every stage is a plain
//   register, so a new request may enter at every edge.
// Path: the request is registered at its accept edge, passes the ack-add
//   stage and the checksum-accumulate stage, and the folded checksum is
//   registered into the output ports together with o_valid.
// Reset: synchronous, active low. Clears every stage valid bit, so requests
//   in flight are dropped; busy is high during reset and until r_run is set
//   after it, then stays low.
// Receiver: it cannot stall; each result is shown for one cycle only.
module tcp_reset_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_src_ip,
    input  logic [31:0] i_dst_ip,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    input  logic [31:0] i_seq_number,
    input  logic [31:0] i_ack_number,
    input  logic [7:0]  i_tcp_flags,
    input  logic [15:0] i_total_length,
    input  logic [3:0]  i_ip_header_words,
    input  logic [3:0]  i_tcp_header_words,
    output logic        o_valid,
    output logic [31:0] o_rst_src_ip,
    output logic [31:0] o_rst_dst_ip,
    output logic [15:0] o_rst_src_port,
    output logic [15:0] o_rst_dst_port,
    output logic [31:0] o_rst_seq,
    output logic [31:0] o_rst_ack,
    output logic [15:0] o_tcp_checksum
);
    import trb_pkg::*;

    logic r_run;
    logic req;
    t_s1  s1;
    t_s2  s3;

    // Hold busy high until the first cycle out of reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= 1'b1;
        end
    end

    assign busy = !r_run;
    assign req  = start && r_run;

    // Decode and pre-sum the header words
    trb_prep u_prep (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_req              (req),
        .i_src_ip           (i_src_ip),
        .i_dst_ip           (i_dst_ip),
        .i_src_port         (i_src_port),
        .i_dst_port         (i_dst_port),
        .i_seq_number       (i_seq_number),
        .i_ack_number       (i_ack_number),
        .i_tcp_flags        (i_tcp_flags),
        .i_total_length     (i_total_length),
        .i_ip_header_words  (i_ip_header_words),
        .i_tcp_header_words (i_tcp_header_words),
        .o_s1               (s1)
    );

    // Build reset ack, then add seq and ack words into the checksum
    trb_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (s1),
        .o_s3    (s3)
    );

    // Fold carries, complement and drive the result ports
    trb_fold u_fold (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s3           (s3),
        .o_valid        (o_valid),
        .o_rst_src_ip   (o_rst_src_ip),
        .o_rst_dst_ip   (o_rst_dst_ip),
        .o_rst_src_port (o_rst_src_port),
        .o_rst_dst_port (o_rst_dst_port),
        .o_rst_seq      (o_rst_seq),
        .o_rst_ack      (o_rst_ack),
        .o_tcp_checksum (o_tcp_checksum)
    );

`ifndef SYNTH
    // Every accepted request comes out as a result on o_valid
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_valid)
        else $error("request did not produce a result after four cycles");

    // No result without a matching earlier request
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 4))
        else $error("result without matching request");

    // Reset seq is zero unless the observed segment carried ACK
    a_seq_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(i_tcp_flags[FlagAck], 4) || o_rst_seq == 32'd0))
        else $error("reset seq nonzero without ACK");

    // Once out of reset, the block never refuses a request
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !busy)
        else $error("busy raised outside reset");
`endif

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for tcp_reset_builder: drives observed header requests and
// checks each reset segment against a predictor of the swap/seq/ack/checksum rules.
// Depends on trb_pkg and the tcp_reset_builder RTL.
module testbench;
    import trb_pkg::*;

    // Cycles with neither a request taken nor a result seen before giving up
    localparam int WatchdogLimit = 2000;
    // Pipeline is four stages deep; let a few more edges pass at the end
    localparam int SettleCycles  = 8;
    // Stop printing mismatch lines after this many, keep counting
    localparam int MaxPrinted    = 100;

    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq_number;
        logic [31:0] ack_number;
        logic [7:0]  tcp_flags;
        logic [15:0] total_length;
        logic [3:0]  ip_header_words;
        logic [3:0]  tcp_header_words;
    } t_tcp_hdr;

    typedef struct packed {
        logic [31:0] rst_src_ip;
        logic [31:0] rst_dst_ip;
        logic [15:0] rst_src_port;
        logic [15:0] rst_dst_port;
        logic [31:0] rst_seq;
        logic [31:0] rst_ack;
        logic [15:0] tcp_checksum;
    } t_rst_seg;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    logic [31:0] i_src_ip           = '0;
    logic [31:0] i_dst_ip           = '0;
    logic [15:0] i_src_port         = '0;
    logic [15:0] i_dst_port         = '0;
    logic [31:0] i_seq_number       = '0;
    logic [31:0] i_ack_number       = '0;
    logic [7:0]  i_tcp_flags        = '0;
    logic [15:0] i_total_length     = '0;
    logic [3:0]  i_ip_header_words  = '0;
    logic [3:0]  i_tcp_header_words = '0;
    logic        o_valid;
    logic [31:0] o_rst_src_ip;
    logic [31:0] o_rst_dst_ip;
    logic [15:0] o_rst_src_port;
    logic [15:0] o_rst_dst_port;
    logic [31:0] o_rst_seq;
    logic [31:0] o_rst_ack;
    logic [15:0] o_tcp_checksum;

    // Reset segments predicted for accepted requests, oldest first
    t_rst_seg expected_resets[$];
    int       mismatch_count = 0;
    int       stall_cycles   = 0;
    // When clear, the sender drives requests back to back
    bit       gaps_on        = 1'b1;

    tcp_reset_builder DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_src_ip           (i_src_ip),
        .i_dst_ip           (i_dst_ip),
        .i_src_port         (i_src_port),
        .i_dst_port         (i_dst_port),
        .i_seq_number       (i_seq_number),
        .i_ack_number       (i_ack_number),
        .i_tcp_flags        (i_tcp_flags),
        .i_total_length     (i_total_length),
        .i_ip_header_words  (i_ip_header_words),
        .i_tcp_header_words (i_tcp_header_words),
        .o_valid            (o_valid),
        .o_rst_src_ip       (o_rst_src_ip),
        .o_rst_dst_ip       (o_rst_dst_ip),
        .o_rst_src_port     (o_rst_src_port),
        .o_rst_dst_port     (o_rst_dst_port),
        .o_rst_seq          (o_rst_seq),
        .o_rst_ack          (o_rst_ack),
        .o_tcp_checksum     (o_tcp_checksum)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Add both 16-bit halves of a 32-bit word to the running checksum
    function automatic logic [31:0] add_halves(logic [31:0] acc, logic [31:0] word);
        return acc + {16'd0, word[31:16]} + {16'd0, word[15:0]};
    endfunction

    function automatic t_rst_seg predict_reset(t_tcp_hdr h);
        t_rst_seg    r;
        logic [31:0] payload;
        logic [31:0] sum;
        // Swap both ends of the connection
        r.rst_src_ip   = h.dst_ip;
        r.rst_dst_ip   = h.src_ip;
        r.rst_src_port = h.dst_port;
        r.rst_dst_port = h.src_port;
        // Take the peer's ack as our seq only when ACK was set
        r.rst_seq = h.tcp_flags[FlagAck] ? h.ack_number : 32'd0;
        // Payload wraps modulo 2^32 when the headers claim more than the packet
        payload = {16'd0, h.total_length} - {26'd0, h.ip_header_words, 2'b00}
                - {26'd0, h.tcp_header_words, 2'b00};
        r.rst_ack = h.seq_number + 32'(h.tcp_flags[FlagSyn])
                  + 32'(h.tcp_flags[FlagFin]) + payload;
        // Pseudo-header plus fixed RST|ACK header, window and urgent zero
        sum = 32'(ProtoTcp) + 32'(TcpHdrBytes) + 32'(RstOffFlags)
            + {16'd0, h.dst_port} + {16'd0, h.src_port};
        sum = add_halves(sum, h.dst_ip);
        sum = add_halves(sum, h.src_ip);
        sum = add_halves(sum, r.rst_seq);
        sum = add_halves(sum, r.rst_ack);
        // Fold the carries back in twice, then complement
        sum = {16'd0, sum[31:16]} + {16'd0, sum[15:0]};
        sum = sum + {16'd0, sum[31:16]};
        r.tcp_checksum = ~sum[15:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        if (mismatch_count < MaxPrinted)
            $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // Sample at the edge: outputs and the request still hold their pre-edge values.
    // Check the result first, then record any request taken at this same edge.
    always @(posedge i_clk) begin
        t_rst_seg want;
        if (i_rst_n) begin
            if ($isunknown(o_valid)) begin
                report_mismatch("o_valid unknown");
            end else if (o_valid) begin
                if (expected_resets.size() == 0) begin
                    report_mismatch("reset segment with no request outstanding");
                end else begin
                    want = expected_resets.pop_front();
                    check_field("rst_src_ip",   o_rst_src_ip,   want.rst_src_ip);
                    check_field("rst_dst_ip",   o_rst_dst_ip,   want.rst_dst_ip);
                    check_field("rst_src_port", 32'(o_rst_src_port),
                                32'(want.rst_src_port));
                    check_field("rst_dst_port", 32'(o_rst_dst_port),
                                32'(want.rst_dst_port));
                    check_field("rst_seq",      o_rst_seq,      want.rst_seq);
                    check_field("rst_ack",      o_rst_ack,      want.rst_ack);
                    check_field("tcp_checksum", 32'(o_tcp_checksum),
                                32'(want.tcp_checksum));
                end
            end
            if (start && busy === 1'b0)
                expected_resets.push_back(predict_reset({i_src_ip, i_dst_ip,
                    i_src_port, i_dst_port, i_seq_number, i_ack_number, i_tcp_flags,
                    i_total_length, i_ip_header_words, i_tcp_header_words}));
        end
    end

    // Watchdog: end the run if traffic stops in both directions
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_valid === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WatchdogLimit) begin
                $display("watchdog: no progress for %0d cycles", WatchdogLimit);
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Well-formed: sane header lengths and a total length that covers them.
    // Otherwise every field is raw random, so payloads can go negative.
    function automatic t_tcp_hdr random_header(bit well_formed);
        t_tcp_hdr h;
        int       hdr_bytes;
        h.src_ip     = $urandom();
        h.dst_ip     = $urandom();
        h.src_port   = 16'($urandom());
        h.dst_port   = 16'($urandom());
        h.ack_number = $urandom();
        h.tcp_flags  = 8'($urandom());
        // Land near the top of the sequence space now and then to hit the wrap
        if ($urandom_range(0, 7) == 0)
            h.seq_number = 32'hffff_ffff - $urandom_range(0, 3000);
        else
            h.seq_number = $urandom();
        if (well_formed) begin
            h.ip_header_words  = 4'($urandom_range(5, 15));
            h.tcp_header_words = 4'($urandom_range(5, 15));
            hdr_bytes = 4 * (h.ip_header_words + h.tcp_header_words);
            if ($urandom_range(0, 3) != 0)
                h.total_length = 16'(hdr_bytes + $urandom_range(0, 1460));
            else
                h.total_length = 16'($urandom_range(hdr_bytes, 65535));
        end else begin
            h.ip_header_words  = 4'($urandom());
            h.tcp_header_words = 4'($urandom());
            h.total_length     = 16'($urandom());
        end
        return h;
    endfunction

    // Present one request and hold it until the block takes it.
    // Returns in the time step of the accepting edge.
    task automatic send_header(t_tcp_hdr h);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_src_ip           <= h.src_ip;
        i_dst_ip           <= h.dst_ip;
        i_src_port         <= h.src_port;
        i_dst_port         <= h.dst_port;
        i_seq_number       <= h.seq_number;
        i_ack_number       <= h.ack_number;
        i_tcp_flags        <= h.tcp_flags;
        i_total_length     <= h.total_length;
        i_ip_header_words  <= h.ip_header_words;
        i_tcp_header_words <= h.tcp_header_words;
        start              <= 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    // Drop start and hold off until every predicted segment has come back.
    // Always advance at least one edge so start is not raised in the same step.
    task automatic wait_for_drain();
        start <= 1'b0;
        do @(posedge i_clk); while (expected_resets.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // All-zero, all-one and alternating bit patterns in every field
    task automatic test_field_extremes();
        t_tcp_hdr h;
        h = '0;
        send_header(h);
        h = '1;
        send_header(h);
        h = {32'haaaa_aaaa, 32'h5555_5555, 16'haaaa, 16'h5555, 32'haaaa_aaaa,
             32'h5555_5555, 8'haa, 16'h5555, 4'ha, 4'h5};
        send_header(h);
        h = {32'h5555_5555, 32'haaaa_aaaa, 16'h5555, 16'haaaa, 32'h5555_5555,
             32'haaaa_aaaa, 8'h55, 16'haaaa, 4'h5, 4'ha};
        send_header(h);
    endtask

    // Each of FIN, SYN, ACK alone and combined; other flag bits must be ignored
    task automatic test_flag_decoding();
        t_tcp_hdr  h;
        logic [7:0] flag_set[8];
        flag_set[0] = 8'h00;
        flag_set[1] = 8'h01 << FlagFin;
        flag_set[2] = 8'h01 << FlagSyn;
        flag_set[3] = 8'h01 << FlagAck;
        flag_set[4] = (8'h01 << FlagSyn) | (8'h01 << FlagAck);
        flag_set[5] = (8'h01 << FlagFin) | (8'h01 << FlagAck) | 8'h08;
        flag_set[6] = (8'h01 << FlagSyn) | (8'h01 << FlagFin);
        // Everything except FIN, SYN and ACK
        flag_set[7] = ~((8'h01 << FlagFin) | (8'h01 << FlagSyn) | (8'h01 << FlagAck));
        foreach (flag_set[i]) begin
            h = random_header(1'b1);
            h.tcp_flags = flag_set[i];
            send_header(h);
        end
    endtask

    // Payload length and sequence arithmetic at their wrap points
    task automatic test_payload_wrap();
        t_tcp_hdr h;
        // Headers far longer than the packet: payload goes negative
        h = random_header(1'b1);
        h.total_length = 16'd0;
        h.ip_header_words = 4'hf;
        h.tcp_header_words = 4'hf;
        send_header(h);
        // Payload of minus one byte
        h.total_length = 16'd39;
        h.ip_header_words = 4'd5;
        h.tcp_header_words = 4'd5;
        send_header(h);
        // Exactly header-sized packet, no payload
        h.total_length = 16'd40;
        send_header(h);
        // Largest payload with zero-length headers
        h.total_length = 16'hffff;
        h.ip_header_words = 4'd0;
        h.tcp_header_words = 4'd0;
        send_header(h);
        // Sequence at the top with SYN and FIN: the ack wraps through zero
        h = random_header(1'b1);
        h.seq_number = 32'hffff_ffff;
        h.tcp_flags = (8'h01 << FlagSyn) | (8'h01 << FlagFin);
        h.total_length = 16'd40;
        h.ip_header_words = 4'd5;
        h.tcp_header_words = 4'd5;
        send_header(h);
    endtask

    // Long stream of mostly well-formed headers with random gaps,
    // pausing for a full drain every hundred requests
    task automatic test_random_stream();
        gaps_on = 1'b1;
        for (int n = 0; n < 480; n++) begin
            send_header(random_header($urandom_range(0, 9) != 0));
            if (n % 100 == 99)
                wait_for_drain();
        end
    endtask

    // Requests at full rate, one per cycle, to fill every pipeline stage
    task automatic test_back_to_back();
        gaps_on = 1'b0;
        repeat (150) send_header(random_header($urandom_range(0, 4) != 0));
        gaps_on = 1'b1;
    endtask

    // Raw random headers, lengths unrelated to each other
    task automatic test_malformed_headers();
        gaps_on = 1'b1;
        repeat (100) send_header(random_header(1'b0));
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_field_extremes();
        test_flag_decoding();
        test_payload_wrap();
        wait_for_drain();
        test_random_stream();
        wait_for_drain();
        test_back_to_back();
        wait_for_drain();
        test_malformed_headers();
        wait_for_drain();

        // Let any stray segment surface before deciding
        repeat (SettleCycles) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

### filelist.f
rtl/trb_pkg.sv
rtl/trb_prep.sv
rtl/trb_acc.sv
rtl/trb_fold.sv
rtl/tcp_reset_builder.sv
bench/testbench.sv
